FILE: rtl/tlbfp_pkg.sv
// shared constants and types for the tlb / demand paging translator
// no dependencies
package tlbfp_pkg;

    localparam int ADDR_W           = 20;
    localparam int FRAME_W          = 11;
    localparam int TLB_ENTRIES_DEF  = 16;
    localparam int PAGE_COUNT_DEF   = 1024;
    localparam int OFFSET_WIDTH_DEF = 10;

    // tlb lookup answer handed to the sequencer
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] frame;
    } lookup_t;

endpackage

FILE: rtl/tlbfp_ram.sv
// generic single-port-write, registered-read ram
// no dependencies
module tlbfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/tlbfp_tlb.sv
// fully associative tlb with fifo fill pointer
// depends on tlbfp_pkg
module tlbfp_tlb #(
    parameter int ENTRIES = tlbfp_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_W  = 10
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [PAGE_W-1:0]             lookup_page,
    output tlbfp_pkg::lookup_t            lookup,
    input  logic                          fill_en,
    input  logic [PAGE_W-1:0]             fill_page,
    input  logic [tlbfp_pkg::FRAME_W-1:0] fill_frame
);
    import tlbfp_pkg::*;

    localparam int SLOT_W = $clog2(ENTRIES);

    logic [PAGE_W-1:0]  page_reg  [ENTRIES];
    logic [FRAME_W-1:0] frame_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic [ENTRIES-1:0] match;
    logic [FRAME_W-1:0] frame_or;

    // pages enter only on a miss, so at most one slot matches
    always_comb
    begin
        frame_or = '0;
        for (int k = 0; k < ENTRIES; k++)
        begin
            match[k] = valid_reg[k] && (page_reg[k] == lookup_page);
            frame_or = frame_or | (match[k] ? frame_reg[k] : '0);
        end
        lookup.hit   = |match;
        lookup.frame = frame_or;
    end

    always_comb
    begin
        valid_next = valid_reg;
        slot_next  = slot_reg;
        if (fill_en)
        begin
            valid_next[slot_reg] = 1'b1;
            if (slot_reg == SLOT_W'(ENTRIES - 1))
            begin
                slot_next = '0;
            end
            else
            begin
                slot_next = slot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            slot_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            slot_reg  <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fill_en)
        begin
            page_reg[slot_reg]  <= fill_page;
            frame_reg[slot_reg] <= fill_frame;
        end
    end

endmodule

FILE: rtl/tlb_fifo_page_translate.sv
// top level: sequencer around the tlb and the page-map ram
// depends on tlbfp_pkg, tlbfp_ram, tlbfp_tlb
//
// Translates one virtual address per transaction into a physical address with
// tlb-hit and page-fault flags. After reset the page map is swept to invalid,
// one entry per cycle, with in_ready low until the sweep is done. A tlb hit
// is answered from the lookup state once the output slot is free; a miss adds
// the read state for the registered read of the page-map ram before the write-back and tlb fill. When
// PAGE_COUNT is not a power of two and the page field can exceed it, the page
// number is first reduced by one compare-subtract per cycle, from the largest
// shifted multiple of PAGE_COUNT down to PAGE_COUNT itself. A finished result waits
// in the output register while the next transaction is accepted.
module tlb_fifo_page_translate #(
    parameter int TLB_ENTRIES  = tlbfp_pkg::TLB_ENTRIES_DEF,
    parameter int PAGE_COUNT   = tlbfp_pkg::PAGE_COUNT_DEF,
    parameter int OFFSET_WIDTH = tlbfp_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tlbfp_pkg::ADDR_W-1:0] virtual_address,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tlbfp_pkg::ADDR_W-1:0] phys_addr,
    output logic                         tlb_hit,
    output logic                         page_fault
);
    import tlbfp_pkg::*;

    localparam int  VPN_W       = ADDR_W - OFFSET_WIDTH;
    localparam int  PAGE_W      = $clog2(PAGE_COUNT);
    localparam bit  IS_POW2     = (PAGE_COUNT & (PAGE_COUNT - 1)) == 0;
    localparam bit  NEED_REDUCE = !IS_POW2 && ((1 << VPN_W) > PAGE_COUNT);
    localparam int  KMAX        = NEED_REDUCE ? VPN_W - PAGE_W : 0;
    localparam int  K_W         = (KMAX > 0) ? $clog2(KMAX + 1) : 1;
    localparam int  REM_W       = ((VPN_W > PAGE_W) ? VPN_W : PAGE_W) + 1;
    localparam int  MAP_W       = FRAME_W + 1;
    localparam int  PA_W        = FRAME_W + OFFSET_WIDTH;

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_REDUCE = 5'b00100,
        S_LOOK   = 5'b01000,
        S_READ   = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [OFFSET_WIDTH-1:0] off_reg, off_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [K_W-1:0]          k_reg, k_next;
    logic [PAGE_W-1:0]       clr_reg, clr_next;
    logic [FRAME_W-1:0]      free_reg, free_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ADDR_W-1:0]       pa_reg, pa_next;
    logic                    hit_reg, hit_next;
    logic                    fault_reg, fault_next;

    logic [PAGE_W-1:0]       page;
    logic [REM_W-1:0]        step_val;
    logic                    slot_free;
    lookup_t                 lookup;
    logic                    fill_en;
    logic [FRAME_W-1:0]      frame_sel;
    logic [PA_W-1:0]         pa_full;
    logic                    ram_we;
    logic [PAGE_W-1:0]       ram_waddr;
    logic [MAP_W-1:0]        ram_wdata;
    logic                    ram_re;
    logic [MAP_W-1:0]        ram_rdata;

    assign page      = rem_reg[PAGE_W-1:0];
    assign step_val  = REM_W'(PAGE_COUNT) << k_reg;
    assign slot_free = !out_valid_reg || out_ready;
    assign pa_full   = {frame_sel, off_reg};

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign phys_addr  = pa_reg;
    assign tlb_hit    = hit_reg;
    assign page_fault = fault_reg;

    tlbfp_tlb #(
        .ENTRIES (TLB_ENTRIES),
        .PAGE_W  (PAGE_W)
    ) u_tlb (
        .clk         (clk),
        .rst_n       (rst_n),
        .lookup_page (page),
        .lookup      (lookup),
        .fill_en     (fill_en),
        .fill_page   (page),
        .fill_frame  (frame_sel)
    );

    // entry: {valid, frame}
    tlbfp_ram #(
        .WIDTH (MAP_W),
        .DEPTH (PAGE_COUNT)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (page),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        off_next       = off_reg;
        rem_next       = rem_reg;
        k_next         = k_reg;
        clr_next       = clr_reg;
        free_next      = free_reg;
        out_valid_next = out_valid_reg;
        pa_next        = pa_reg;
        hit_next       = hit_reg;
        fault_next     = fault_reg;
        fill_en        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = page;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        frame_sel      = lookup.frame;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == PAGE_W'(PAGE_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    off_next   = virtual_address[OFFSET_WIDTH-1:0];
                    rem_next   = REM_W'(virtual_address[ADDR_W-1:OFFSET_WIDTH]);
                    k_next     = K_W'(KMAX);
                    state_next = NEED_REDUCE ? S_REDUCE : S_LOOK;
                end
            end
            S_REDUCE:
            begin
                // restoring reduction of the page field modulo the page count
                if (rem_reg >= step_val)
                begin
                    rem_next = rem_reg - step_val;
                end
                k_next = k_reg - 1'b1;
                if (k_reg == '0)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (slot_free)
                begin
                    if (lookup.hit)
                    begin
                        out_valid_next = 1'b1;
                        pa_next        = ADDR_W'(pa_full);
                        hit_next       = 1'b1;
                        fault_next     = 1'b0;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        ram_re     = 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                // output slot stays free since the lookup state left it empty on the miss path
                if (ram_rdata[MAP_W-1])
                begin
                    frame_sel  = ram_rdata[FRAME_W-1:0];
                    fault_next = 1'b0;
                end
                else
                begin
                    frame_sel  = free_reg;
                    fault_next = 1'b1;
                    ram_we     = 1'b1;
                    ram_wdata  = {1'b1, free_reg};
                    free_next  = free_reg + 1'b1;
                end
                fill_en        = 1'b1;
                out_valid_next = 1'b1;
                pa_next        = ADDR_W'(pa_full);
                hit_next       = 1'b0;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_reg      <= free_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg   <= off_next;
        rem_reg   <= rem_next;
        k_reg     <= k_next;
        pa_reg    <= pa_next;
        hit_reg   <= hit_next;
        fault_reg <= fault_next;
    end

endmodule

FILE: bench/tlb_fifo_page_translate_tb.sv
// testbench for tlb_fifo_page_translate: directed and random address streams
// with random idling on both channels, checked against a scoreboard that
// tracks the tlb, the page map and the frame counter. depends on tlbfp_pkg
`timescale 1ns / 100ps

module tlb_fifo_page_translate_tb;

    import tlbfp_pkg::*;

    localparam int TLB_SLOTS    = TLB_ENTRIES_DEF;
    localparam int PAGES        = PAGE_COUNT_DEF;
    localparam int OFS_W        = OFFSET_WIDTH_DEF;
    localparam int PAGE_W       = ADDR_W - OFS_W;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOT_PAGES    = 24;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int IDLE_PCT     = 31;

    typedef struct {
        logic [ADDR_W-1:0] phys;
        logic              hit;
        logic              fault;
    } translation_t;

    class xlate_scoreboard;
        logic [PAGE_W-1:0]  slot_page  [TLB_SLOTS];
        logic [FRAME_W-1:0] slot_frame [TLB_SLOTS];
        bit                 slot_valid [TLB_SLOTS];
        int                 fill_ptr;
        logic [FRAME_W-1:0] map_frame  [PAGES];
        bit                 mapped     [PAGES];
        logic [FRAME_W-1:0] frame_counter;
        translation_t       expected_translations[$];
        int                 mismatches;

        function new();
            foreach (slot_valid[k])
                slot_valid[k] = 0;
            foreach (mapped[p])
                mapped[p] = 0;
            fill_ptr      = 0;
            frame_counter = '0;
            mismatches    = 0;
        endfunction

        // lookup, page walk on a miss, fifo fill of the tlb
        function translation_t translate(logic [ADDR_W-1:0] va);
            translation_t       t;
            int                 page;
            logic [FRAME_W-1:0] frame;
            page    = int'(va >> OFS_W) % PAGES;
            frame   = '0;
            t.hit   = 1'b0;
            t.fault = 1'b0;
            for (int k = 0; k < TLB_SLOTS; k++)
            begin
                if (slot_valid[k] && slot_page[k] == PAGE_W'(page))
                begin
                    frame = slot_frame[k];
                    t.hit = 1'b1;
                    break;
                end
            end
            if (!t.hit)
            begin
                if (mapped[page])
                begin
                    frame = map_frame[page];
                end
                else
                begin
                    t.fault         = 1'b1;
                    frame           = frame_counter;
                    map_frame[page] = frame;
                    mapped[page]    = 1;
                    frame_counter   = frame_counter + 1'b1;
                end
                slot_page[fill_ptr]  = PAGE_W'(page);
                slot_frame[fill_ptr] = frame;
                slot_valid[fill_ptr] = 1;
                fill_ptr             = (fill_ptr + 1) % TLB_SLOTS;
            end
            // frame bits above the address width fall off
            t.phys = ADDR_W'({frame, va[OFS_W-1:0]});
            return t;
        endfunction

        function void note_address(logic [ADDR_W-1:0] va);
            expected_translations.push_back(translate(va));
        endfunction

        function void check_translation(logic [ADDR_W-1:0] phys, logic hit, logic fault);
            translation_t exp_t;
            if (expected_translations.size() == 0)
            begin
                $display("%0t: unexpected transaction phys=%h hit=%b fault=%b",
                         $time, phys, hit, fault);
                mismatches++;
                return;
            end
            exp_t = expected_translations.pop_front();
            if (phys !== exp_t.phys)
            begin
                $display("%0t: phys_addr expected %h actual %h",
                         $time, exp_t.phys, phys);
                mismatches++;
            end
            if (hit !== exp_t.hit)
            begin
                $display("%0t: tlb_hit expected %b actual %b", $time, exp_t.hit, hit);
                mismatches++;
            end
            if (fault !== exp_t.fault)
            begin
                $display("%0t: page_fault expected %b actual %b",
                         $time, exp_t.fault, fault);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_translations.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [ADDR_W-1:0] virtual_address;
    logic              out_valid;
    logic              out_ready;
    logic [ADDR_W-1:0] phys_addr;
    logic              tlb_hit;
    logic              page_fault;

    xlate_scoreboard sb = new();
    bit              steady = 0;
    int              cycle_count = 0;

    tlb_fifo_page_translate dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .virtual_address (virtual_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .phys_addr       (phys_addr),
        .tlb_hit         (tlb_hit),
        .page_fault      (page_fault)
    );

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        virtual_address = '0;
        out_ready       = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: check accepted transactions, stall at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_ready)
            sb.check_translation(phys_addr, tlb_hit, page_fault);
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // called at a rising edge; valid stays high from one transaction to the next unless a random idle is drawn
    task automatic send_address(input logic [ADDR_W-1:0] va);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        virtual_address <= va;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_address(va);
    endtask

    function automatic logic [ADDR_W-1:0] page_addr(int page, int offset);
        return {PAGE_W'(page), OFS_W'(offset)};
    endfunction

    initial
    begin
        int hot[HOT_PAGES];
        int recent[$];
        int page;
        int pick;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, hits, fifo eviction, refill from the page map
        send_address(20'h00000);
        send_address(20'h003FF);
        send_address(20'hFFFFF);
        send_address(20'hFFC00);
        for (int p = 1; p <= 15; p++)
            send_address(page_addr(p, $urandom_range((1 << OFS_W) - 1)));
        send_address(20'h00155);
        send_address(20'hFFEAA);
        send_address(page_addr(5, 'h2AA));
        send_address(20'hAAAAA);
        send_address(20'h55555);

        foreach (hot[k])
            hot[k] = $urandom_range(PAGES - 1);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            steady = (n >= 250 && n < 400);
            pick   = $urandom_range(99);
            if (pick < 35 && recent.size() > 0)
                page = recent[$urandom_range(recent.size() - 1)];
            else if (pick < 70)
                page = hot[$urandom_range(HOT_PAGES - 1)];
            else
                page = $urandom_range(PAGES - 1);
            recent.push_back(page);
            if (recent.size() > TLB_SLOTS)
                void'(recent.pop_front());
            send_address(page_addr(page, $urandom_range((1 << OFS_W) - 1)));
        end
        steady   = 0;
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: tlb_fifo_page_translate.f
rtl/tlbfp_pkg.sv
rtl/tlbfp_ram.sv
rtl/tlbfp_tlb.sv
rtl/tlb_fifo_page_translate.sv
bench/tlb_fifo_page_translate_tb.sv
